@@ src/chtc_pkg.sv @@
// Shared types, constants and lookup functions for the chiptune header track counter.
// No dependencies; imported by every module of the block.
package chtc_pkg;

    localparam int SCAN_WINDOW = 256;
    localparam int KEY_MAX     = 128;
    localparam int POS_CAP     = SCAN_WINDOW + 32;
    localparam int POS_W       = $clog2(POS_CAP + 1);
    localparam int KEY_W       = $clog2(KEY_MAX + 1);

    localparam logic [7:0] BYTE_FF    = 8'hff;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_QUOTE = 8'h22;
    localparam logic [7:0] KSS_VER    = 8'h10;

    localparam logic [POS_W-1:0] POS_NSF_CNT = POS_W'(6);
    localparam logic [POS_W-1:0] POS_GBS_CNT = POS_W'(4);
    localparam logic [POS_W-1:0] POS_KSS_VER = POS_W'(8'h0e);
    localparam logic [POS_W-1:0] POS_KSS_LO  = POS_W'(8'h1a);
    localparam logic [POS_W-1:0] POS_KSS_HI  = POS_W'(8'h1b);
    localparam logic [POS_W-1:0] POS_AY_CNT  = POS_W'(8'h10);

    typedef enum logic [2:0] {
        MODE_NSF = 3'd0,
        MODE_GBS = 3'd1,
        MODE_KSS = 3'd2,
        MODE_AY  = 3'd3,
        MODE_SAP = 3'd4
    } mode_t;

    // Per-byte classification used by the SAP line parser
    typedef struct packed {
        logic       is_ff;
        logic       is_cr;
        logic       is_lf;
        logic       is_space;
        logic       is_quote;
        logic [3:0] hex;
    } byte_cls_t;

    // One classified byte, front to back
    typedef struct packed {
        logic [2:0] mode;
        logic       last;
        logic [7:0] data;
        byte_cls_t  cls;
        logic       magic_bad;
        logic       cap_low_en;
        logic       cap_high_en;
        logic       kss_en;
        logic       kss_val;
        logic       scan_en;
        logic       len_ok;
    } chtc_item_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] m, input logic [2:0] idx);
        logic [63:0] row;
        begin
            unique case (m)
                MODE_NSF: row = {8'h00, 8'h00, 8'h00, 8'h1a, "M", "S", "E", "N"};
                MODE_GBS: row = {8'h00, 8'h00, 8'h00, 8'h00, 8'h01, "S", "B", "G"};
                MODE_KSS: row = {8'h00, 8'h00, 8'h00, 8'h00, "X", "S", "S", "K"};
                MODE_AY:  row = {"L", "U", "M", "E", "Y", "A", "X", "Z"};
                MODE_SAP: row = {8'h00, 8'h00, 8'h00, 8'h0a, 8'h0d, "P", "A", "S"};
                default:  row = '0;
            endcase
            magic_byte = row[idx*8 +: 8];
        end
    endfunction

    function automatic logic [3:0] magic_len(input logic [2:0] m);
        unique case (m)
            MODE_NSF: magic_len = 4'd5;
            MODE_GBS: magic_len = 4'd4;
            MODE_KSS: magic_len = 4'd4;
            MODE_AY:  magic_len = 4'd8;
            MODE_SAP: magic_len = 4'd5;
            default:  magic_len = 4'd0;
        endcase
    endfunction

    // Minimum file length per format
    function automatic logic [POS_W-1:0] need_len(input logic [2:0] m);
        unique case (m)
            MODE_NSF: need_len = POS_W'(7);
            MODE_GBS: need_len = POS_W'(5);
            MODE_KSS: need_len = POS_W'(32);
            MODE_AY:  need_len = POS_W'(17);
            MODE_SAP: need_len = POS_W'(16);
            default:  need_len = '0;
        endcase
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] idx);
        unique case (idx)
            3'd0:    key_char = "S";
            3'd1:    key_char = "O";
            3'd2:    key_char = "N";
            3'd3:    key_char = "G";
            3'd4:    key_char = "S";
            default: key_char = 8'h00;
        endcase
    endfunction

endpackage

@@ src/chtc_front.sv @@
// Front end: tracks the byte offset and classifies each incoming byte.
// Depends on chtc_pkg.
module chtc_front
    import chtc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [2:0]       mode,
    input  logic [7:0]       data_byte,
    input  logic             last,
    output chtc_item_t       item
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] len;
    logic [3:0]       mlen;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            hex_digit = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            hex_digit = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            hex_digit = 4'(c - "A" + 8'd10);
        else
            hex_digit = 4'd0;
    endfunction

    always_comb
    begin
        mlen = magic_len(mode);
        len  = (pos_reg < POS_W'(POS_CAP)) ? pos_reg + POS_W'(1) : pos_reg;

        item.mode         = mode;
        item.last         = last;
        item.data         = data_byte;
        item.cls.is_ff    = (data_byte == BYTE_FF);
        item.cls.is_cr    = (data_byte == BYTE_CR);
        item.cls.is_lf    = (data_byte == BYTE_LF);
        item.cls.is_space = (data_byte == BYTE_SPACE);
        item.cls.is_quote = (data_byte == BYTE_QUOTE);
        item.cls.hex      = hex_digit(data_byte);
        item.magic_bad    = (pos_reg < POS_W'(mlen))
                            && (data_byte != magic_byte(mode, pos_reg[2:0]));
        item.cap_low_en   = ((mode == MODE_NSF) && (pos_reg == POS_NSF_CNT))
                            || ((mode == MODE_GBS) && (pos_reg == POS_GBS_CNT))
                            || ((mode == MODE_KSS) && (pos_reg == POS_KSS_LO))
                            || ((mode == MODE_AY) && (pos_reg == POS_AY_CNT));
        item.cap_high_en  = (mode == MODE_KSS) && (pos_reg == POS_KSS_HI);
        item.kss_en       = (mode == MODE_KSS) && (pos_reg == POS_KSS_VER);
        item.kss_val      = (data_byte == KSS_VER);
        item.scan_en      = (pos_reg < POS_W'(SCAN_WINDOW));
        item.len_ok       = (len >= need_len(mode));
    end

    // Restart the offset after the final byte of a file
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (last)
                pos_next = '0;
            else
                pos_next = len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

@@ src/chtc_queue.sv @@
// Two-entry queue of classified bytes between the front and back ends.
// Depends on chtc_pkg.
module chtc_queue
    import chtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  chtc_item_t wr_item,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output chtc_item_t rd_item
);

    chtc_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

@@ src/chtc_back.sv @@
// Back end: applies each classified byte to the header state, runs the SAP
// line parser and holds the result register. Depends on chtc_pkg.
module chtc_back
    import chtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  chtc_item_t  in_item,
    output logic        in_take,
    output logic        res_valid,
    input  logic        res_pop,
    output logic        res_found,
    output logic [31:0] res_count
);

    logic             magic_ok_reg,     magic_ok_next;
    logic [7:0]       cap_low_reg,      cap_low_next;
    logic [7:0]       cap_high_reg,     cap_high_next;
    logic             kss_ok_reg,       kss_ok_next;
    logic [7:0]       held_byte_reg,    held_byte_next;
    byte_cls_t        held_cls_reg,     held_cls_next;
    logic             held_valid_reg,   held_valid_next;
    logic             in_value_reg,     in_value_next;
    logic [KEY_W-1:0] key_len_reg,      key_len_next;
    logic             key_bad_reg,      key_bad_next;
    logic [31:0]      accum_reg,        accum_next;
    logic [1:0]       quoted_reg,       quoted_next;
    logic [31:0]      songs_count_reg,  songs_count_next;
    logic             songs_seen_reg,   songs_seen_next;
    logic             stopped_reg,      stopped_next;
    logic             res_valid_reg,    res_valid_next;
    logic             res_found_reg,    res_found_next;
    logic [31:0]      res_count_reg,    res_count_next;

    logic        found;
    logic [31:0] count;

    // Stall only a final byte while an untaken result occupies the register
    assign in_take   = in_valid && (!in_item.last || !res_valid_reg || res_pop);
    assign res_valid = res_valid_reg;
    assign res_found = res_found_reg;
    assign res_count = res_count_reg;

    always_comb
    begin
        magic_ok_next    = magic_ok_reg & ~in_item.magic_bad;
        cap_low_next     = in_item.cap_low_en  ? in_item.data : cap_low_reg;
        cap_high_next    = in_item.cap_high_en ? in_item.data : cap_high_reg;
        kss_ok_next      = in_item.kss_en ? in_item.kss_val : kss_ok_reg;
        held_byte_next   = held_byte_reg;
        held_cls_next    = held_cls_reg;
        held_valid_next  = held_valid_reg;
        in_value_next    = in_value_reg;
        key_len_next     = key_len_reg;
        key_bad_next     = key_bad_reg;
        accum_next       = accum_reg;
        quoted_next      = quoted_reg;
        songs_count_next = songs_count_reg;
        songs_seen_next  = songs_seen_reg;
        stopped_next     = stopped_reg;

        if (!stopped_reg && in_item.scan_en)
        begin
            if (!held_valid_reg)
            begin
                held_byte_next  = in_item.data;
                held_cls_next   = in_item.cls;
                held_valid_next = 1'b1;
            end
            else if (held_cls_reg.is_ff && in_item.cls.is_ff)
            begin
                stopped_next = 1'b1;
            end
            else if (held_cls_reg.is_cr && in_item.cls.is_lf)
            begin
                // End of line: latch a SONGS value, then clear the line
                if (!key_bad_reg && (key_len_reg == KEY_W'(5)))
                begin
                    songs_count_next = (quoted_reg == 2'd2) ? 32'd0 : accum_reg;
                    songs_seen_next  = 1'b1;
                end
                in_value_next   = 1'b0;
                key_len_next    = '0;
                key_bad_next    = 1'b0;
                accum_next      = '0;
                quoted_next     = 2'd0;
                held_valid_next = 1'b0;
            end
            else
            begin
                if (held_cls_reg.is_space)
                    in_value_next = 1'b1;
                else if (!in_value_reg)
                begin
                    if (key_len_reg < KEY_W'(KEY_MAX))
                    begin
                        if ((key_len_reg >= KEY_W'(5))
                            || (held_byte_reg != key_char(key_len_reg[2:0])))
                            key_bad_next = 1'b1;
                        key_len_next = key_len_reg + KEY_W'(1);
                    end
                    else
                        key_bad_next = 1'b1;
                end
                else
                begin
                    if (quoted_reg == 2'd0)
                        quoted_next = held_cls_reg.is_quote ? 2'd2 : 2'd1;
                    accum_next = {accum_reg[27:0], held_cls_reg.hex};
                end
                held_byte_next = in_item.data;
                held_cls_next  = in_item.cls;
            end
        end
    end

    // Judge the file under the mode given with its final byte
    always_comb
    begin
        found = 1'b0;
        count = '0;
        unique case (in_item.mode)
            MODE_NSF:
            begin
                found = magic_ok_next && in_item.len_ok;
                count = {24'd0, cap_low_next};
            end
            MODE_GBS:
            begin
                found = magic_ok_next && in_item.len_ok;
                count = {24'd0, cap_low_next};
            end
            MODE_KSS:
            begin
                found = magic_ok_next && in_item.len_ok && kss_ok_next;
                count = {16'd0, cap_high_next, cap_low_next};
            end
            MODE_AY:
            begin
                found = magic_ok_next && in_item.len_ok;
                count = {23'd0, {1'b0, cap_low_next} + 9'd1};
            end
            MODE_SAP:
            begin
                found = magic_ok_next && in_item.len_ok && songs_seen_next;
                count = songs_count_next;
            end
            default:
            begin
                found = 1'b0;
                count = '0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_found_next = res_found_reg;
        res_count_next = res_count_reg;
        if (res_pop)
            res_valid_next = 1'b0;
        if (in_take && in_item.last)
        begin
            res_valid_next = 1'b1;
            res_found_next = found;
            res_count_next = found ? count : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_ok_reg    <= 1'b1;
            cap_low_reg     <= '0;
            cap_high_reg    <= '0;
            kss_ok_reg      <= 1'b0;
            held_valid_reg  <= 1'b0;
            in_value_reg    <= 1'b0;
            key_len_reg     <= '0;
            key_bad_reg     <= 1'b0;
            accum_reg       <= '0;
            quoted_reg      <= 2'd0;
            songs_count_reg <= '0;
            songs_seen_reg  <= 1'b0;
            stopped_reg     <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (in_take)
            begin
                if (in_item.last)
                begin
                    // Drop all file state so the next byte opens a new file
                    magic_ok_reg    <= 1'b1;
                    cap_low_reg     <= '0;
                    cap_high_reg    <= '0;
                    kss_ok_reg      <= 1'b0;
                    held_valid_reg  <= 1'b0;
                    in_value_reg    <= 1'b0;
                    key_len_reg     <= '0;
                    key_bad_reg     <= 1'b0;
                    accum_reg       <= '0;
                    quoted_reg      <= 2'd0;
                    songs_count_reg <= '0;
                    songs_seen_reg  <= 1'b0;
                    stopped_reg     <= 1'b0;
                end
                else
                begin
                    magic_ok_reg    <= magic_ok_next;
                    cap_low_reg     <= cap_low_next;
                    cap_high_reg    <= cap_high_next;
                    kss_ok_reg      <= kss_ok_next;
                    held_valid_reg  <= held_valid_next;
                    in_value_reg    <= in_value_next;
                    key_len_reg     <= key_len_next;
                    key_bad_reg     <= key_bad_next;
                    accum_reg       <= accum_next;
                    quoted_reg      <= quoted_next;
                    songs_count_reg <= songs_count_next;
                    songs_seen_reg  <= songs_seen_next;
                    stopped_reg     <= stopped_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            held_byte_reg <= held_byte_next;
            held_cls_reg  <= held_cls_next;
        end
        res_found_reg <= res_found_next;
        res_count_reg <= res_count_next;
    end

endmodule

@@ src/chiptune_header_track_count.sv @@
// Chiptune header track counter: top level. An accepted final byte is written
// to a queue slot; the back end reads the slot, and its state update registers
// the result on the result ports. Throughput: one byte per cycle, set by the
// back end's single per-byte state update; a final byte waits while an
// unpopped result is held. Reset (rst_n low, asynchronous) empties the queue
// and the result register and returns all file state to its start; no clearing
// pass is needed. Depends on chtc_pkg, chtc_front, chtc_queue and chtc_back.
module chiptune_header_track_count
    import chtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic        found,
    output logic [31:0] track_count
);

    chtc_item_t front_item;
    chtc_item_t back_item;
    logic       in_fire;
    logic       back_valid;
    logic       back_take;
    logic       res_valid;

    // An input transaction completes when the queue has room
    assign in_fire = push && !full;
    assign empty   = !res_valid;

    // Front: hold the byte offset, compare magic bytes, flag capture offsets
    // and classify the byte for the SAP line parser.
    chtc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_fire),
        .mode      (mode),
        .data_byte (data_byte),
        .last      (last),
        .item      (front_item)
    );

    // Two slots decouple the front from a back end stalled on a full result.
    chtc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_fire),
        .wr_item  (front_item),
        .full     (full),
        .rd_en    (back_take),
        .rd_valid (back_valid),
        .rd_item  (back_item)
    );

    // Back: advance the header state one byte per cycle; a final byte
    // waits only while the previous result has not been popped.
    chtc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (back_valid),
        .in_item   (back_item),
        .in_take   (back_take),
        .res_valid (res_valid),
        .res_pop   (pop && res_valid),
        .res_found (found),
        .res_count (track_count)
    );

endmodule
